[hw/rtl/assert_macros.svh]
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted.
`define MTNE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("port assertion failed");

// Clocked check that also runs through reset.
`define MTNE_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("reset assertion failed");

`endif

[hw/rtl/mtne_pkg.sv]
// Shared types and constants of the MIDI track note extractor.
package mtne_pkg;

    localparam int KEY_W = 7;
    localparam int OUT_TIME_W = 32;

    localparam logic REQ_BYTE    = 1'b0;
    localparam logic REQ_RESTART = 1'b1;

    localparam logic KIND_NOTE = 1'b0;
    localparam logic KIND_EOT  = 1'b1;

    // Status and meta codes of the track format.
    localparam logic [7:0] STATUS_TYPE_MASK  = 8'hF0;
    localparam logic [7:0] ST_NOTE_OFF       = 8'h80;
    localparam logic [7:0] ST_NOTE_ON        = 8'h90;
    localparam logic [7:0] ST_PROGRAM        = 8'hC0;
    localparam logic [7:0] ST_CHAN_PRESSURE  = 8'hD0;
    localparam logic [7:0] ST_SYSEX          = 8'hF0;
    localparam logic [7:0] ST_SYSEX_ESC      = 8'hF7;
    localparam logic [7:0] ST_META           = 8'hFF;
    localparam logic [7:0] META_END_OF_TRACK = 8'h2F;

    // Key table operation decoded from one accepted byte.
    typedef struct packed {
        logic             press;
        logic             release_key;
        logic             eot;
        logic [KEY_W-1:0] key;
    } t_key_op;

    typedef struct packed {
        logic                  kind;
        logic [KEY_W-1:0]      key;
        logic [OUT_TIME_W-1:0] start_time;
        logic [OUT_TIME_W-1:0] duration;
    } t_result;

endpackage

[hw/rtl/mtne_if.sv]
// Request and result channel interfaces.
interface mtne_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] data_byte;

    modport source (output valid, output req_type, output data_byte, input ready);
    modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

interface mtne_res_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [6:0]  key;
    logic [31:0] start_time;
    logic [31:0] duration;

    modport source (output valid, output kind, output key, output start_time,
                    output duration, input ready);
    modport sink   (input valid, input kind, input key, input start_time,
                    input duration, output ready);
endinterface

[hw/rtl/midi_track_note_extractor.sv]
// Top level of the MIDI track note extractor.
// Throughput: one track byte or restart request per cycle while the skid register is free.
// A result goes to the output register, or to the skid register while that one is stalled.
// The rate is set by the single press-time RAM read, issued on every accepted track byte.
// Reset (synchronous, active low) clears parser, key active bits and buffer;
// the press-time RAM is not cleared, entries are used only after a press.
module midi_track_note_extractor
    import mtne_pkg::*;
#(
    parameter int NUM_KEYS  = 128,
    parameter int TIME_BITS = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_we,
    input  logic     i_cfg_wdata,
    mtne_req_if.sink i_req,
    mtne_res_if.source o_res
);

    // configuration: note-on with zero velocity counts as a release
    logic    r_zero_vel_rel;

    logic                 accept;
    logic                 buf_ready;
    logic                 clear;
    t_key_op              op;
    logic [TIME_BITS-1:0] abs_time;
    logic                 res_valid;
    t_result              res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_vel_rel <= 1'b0;
        end else if (i_cfg_we) begin
            r_zero_vel_rel <= i_cfg_wdata;
        end
    end

    // A request is taken whenever the skid register is free, so a result
    // waiting in the output register does not hold up the byte stream.
    assign i_req.ready = buf_ready;
    assign accept      = i_req.valid && buf_ready;

    // Parser: tracks the event phase, the delta and absolute tick times,
    // running status and the skip count of meta, sysex and other data bytes, and hands note
    // press/release and end-of-track operations to the key table.
    mtne_parser #(
        .TIME_BITS (TIME_BITS)
    ) u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_req_type     (i_req.req_type),
        .i_data_byte    (i_req.data_byte),
        .i_zero_vel_rel (r_zero_vel_rel),
        .o_op           (op),
        .o_clear        (clear),
        .o_abs_time     (abs_time)
    );

    // Key table: every accepted track byte reads the press time at its low
    // seven bits; only the read on a note's key byte is ever used, by the
    // velocity byte that always follows it.
    mtne_key_table #(
        .NUM_KEYS  (NUM_KEYS),
        .TIME_BITS (TIME_BITS)
    ) u_keys (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (clear),
        .i_op        (op),
        .i_rd_en     (accept && (i_req.req_type == REQ_BYTE)),
        .i_rd_key    (i_req.data_byte[KEY_W-1:0]),
        .i_abs_time  (abs_time),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Output register with skid entry.
    mtne_out_buf u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (res_valid),
        .i_data     (res),
        .o_in_ready (buf_ready),
        .o_res      (o_res)
    );

endmodule

[hw/rtl/mtne_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module mtne_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/mtne_parser.sv]
// Track byte parser: delta times, status decode, length skipping.
module mtne_parser
    import mtne_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic                 i_req_type,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_zero_vel_rel,
    output t_key_op              o_op,
    output logic                 o_clear,
    output logic [TIME_BITS-1:0] o_abs_time
);

    localparam logic [3:0] PH_DELTA     = 4'd0;
    localparam logic [3:0] PH_STATUS    = 4'd1;
    localparam logic [3:0] PH_VEL       = 4'd2;
    localparam logic [3:0] PH_SKIP      = 4'd3;
    localparam logic [3:0] PH_META_TYPE = 4'd4;
    localparam logic [3:0] PH_LEN       = 4'd5;
    localparam logic [3:0] PH_EOT_LEN   = 4'd6;
    localparam logic [3:0] PH_DONE      = 4'd7;
    localparam logic [3:0] PH_FIRST     = 4'd8;

    logic [3:0]           r_phase, n_phase;
    logic [TIME_BITS-1:0] r_delta, n_delta;
    logic [TIME_BITS-1:0] r_abs, n_abs;
    logic [7:0]           r_status, n_status;
    logic [KEY_W-1:0]     r_held, n_held;
    logic [31:0]          r_skip, n_skip;

    logic [TIME_BITS-1:0] delta_shift;
    logic [31:0]          skip_shift;
    logic [31:0]          skip_dec;
    logic                 do_first;
    logic [7:0]           status_hi;
    t_key_op              op;

    assign delta_shift = {r_delta[TIME_BITS-8:0], i_data_byte[6:0]};
    assign skip_shift  = {r_skip[24:0], i_data_byte[6:0]};
    assign skip_dec    = r_skip - 32'd1;
    assign status_hi   = r_status & STATUS_TYPE_MASK;

    always_comb begin
        n_phase  = r_phase;
        n_delta  = r_delta;
        n_abs    = r_abs;
        n_status = r_status;
        n_held   = r_held;
        n_skip   = r_skip;
        do_first = 1'b0;
        op       = '0;
        if (i_accept && (i_req_type == REQ_RESTART)) begin
            n_phase  = PH_DELTA;
            n_delta  = '0;
            n_abs    = '0;
            n_status = '0;
            n_held   = '0;
            n_skip   = '0;
        end else if (i_accept) begin
            case (r_phase)
                PH_DELTA: begin
                    n_delta = delta_shift;
                    if (!i_data_byte[7]) begin
                        n_abs   = r_abs + delta_shift;
                        n_delta = '0;
                        n_phase = PH_STATUS;
                    end
                end
                PH_STATUS: begin
                    if (!i_data_byte[7]) begin
                        if (r_status == 8'd0) begin
                            n_phase = PH_DELTA;
                        end else begin
                            do_first = 1'b1;
                        end
                    end else if (i_data_byte == ST_META) begin
                        n_status = '0;
                        n_phase  = PH_META_TYPE;
                    end else if (i_data_byte inside {ST_SYSEX, ST_SYSEX_ESC}) begin
                        n_status = '0;
                        n_skip   = '0;
                        n_phase  = PH_LEN;
                    end else if (i_data_byte >= ST_SYSEX) begin
                        n_status = '0;
                        n_phase  = PH_DELTA;
                    end else begin
                        n_status = i_data_byte;
                        n_skip   = '0;
                        n_phase  = PH_FIRST;
                    end
                end
                PH_FIRST: begin
                    do_first = 1'b1;
                end
                PH_VEL: begin
                    n_phase = PH_DELTA;
                    op.key  = r_held;
                    if ((status_hi == ST_NOTE_ON) &&
                        ((i_data_byte[6:0] != 7'd0) || !i_zero_vel_rel)) begin
                        op.press = 1'b1;
                    end else begin
                        op.release_key = 1'b1;
                    end
                end
                PH_SKIP: begin
                    n_skip = skip_dec;
                    if (skip_dec == 32'd0) begin
                        n_phase = PH_DELTA;
                    end
                end
                PH_META_TYPE: begin
                    n_skip  = '0;
                    n_phase = (i_data_byte == META_END_OF_TRACK) ? PH_EOT_LEN : PH_LEN;
                end
                PH_LEN, PH_EOT_LEN: begin
                    n_skip = skip_shift;
                    if (!i_data_byte[7]) begin
                        if (skip_shift != 32'd0) begin
                            n_phase = PH_SKIP;
                        end else if (r_phase == PH_EOT_LEN) begin
                            n_phase = PH_DONE;
                            op.eot  = 1'b1;
                        end else begin
                            n_phase = PH_DELTA;
                        end
                    end
                end
                PH_DONE: begin
                    n_phase = PH_DONE;
                end
                default: begin
                    n_phase = PH_DELTA;
                end
            endcase

            // first data byte of a channel message
            if (do_first) begin
                if ((status_hi == ST_NOTE_OFF) || (status_hi == ST_NOTE_ON)) begin
                    n_held  = i_data_byte[6:0];
                    n_phase = PH_VEL;
                end else if ((status_hi == ST_PROGRAM) ||
                             (status_hi == ST_CHAN_PRESSURE)) begin
                    n_phase = PH_DELTA;
                end else begin
                    n_skip  = 32'd1;
                    n_phase = PH_SKIP;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_DELTA;
            r_delta  <= '0;
            r_abs    <= '0;
            r_status <= '0;
            r_held   <= '0;
            r_skip   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_delta  <= n_delta;
            r_abs    <= n_abs;
            r_status <= n_status;
            r_held   <= n_held;
            r_skip   <= n_skip;
        end
    end

    assign o_op       = op;
    assign o_clear    = i_accept && (i_req_type == REQ_RESTART);
    assign o_abs_time = r_abs;

endmodule

[hw/rtl/mtne_key_table.sv]
// Held-key table: active bits in flops, press times in RAM, note results.
module mtne_key_table
    import mtne_pkg::*;
#(
    parameter int NUM_KEYS  = 128,
    parameter int TIME_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_clear,
    input  t_key_op              i_op,
    input  logic                 i_rd_en,
    input  logic [KEY_W-1:0]     i_rd_key,
    input  logic [TIME_BITS-1:0] i_abs_time,
    output logic                 o_res_valid,
    output t_result              o_res
);

    localparam int KAW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    logic [NUM_KEYS-1:0]  r_active, n_active;
    logic [TIME_BITS-1:0] start_q;
    logic [TIME_BITS-1:0] dur;
    logic [KAW-1:0]       idx;
    logic                 op_in_range;
    logic                 rd_in_range;
    logic                 hit;

    assign idx         = i_op.key[KAW-1:0];
    assign op_in_range = ({1'b0, i_op.key} < 8'(NUM_KEYS));
    assign rd_in_range = ({1'b0, i_rd_key} < 8'(NUM_KEYS));
    assign hit         = i_op.release_key && op_in_range && r_active[idx];

    // The key byte always precedes its velocity byte, so the press time
    // read on the key byte is waiting in the read register here.
    mtne_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (NUM_KEYS)
    ) u_start_ram (
        .i_clk   (i_clk),
        .i_we    (i_op.press && op_in_range),
        .i_waddr (idx),
        .i_wdata (i_abs_time),
        .i_re    (i_rd_en && rd_in_range),
        .i_raddr (i_rd_key[KAW-1:0]),
        .o_rdata (start_q)
    );

    assign dur = i_abs_time - start_q;

    always_comb begin
        n_active = r_active;
        if (i_clear) begin
            n_active = '0;
        end else if (i_op.press && op_in_range) begin
            n_active[idx] = 1'b1;
        end else if (hit) begin
            n_active[idx] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else begin
            r_active <= n_active;
        end
    end

    always_comb begin
        o_res = '0;
        o_res_valid = 1'b0;
        if (i_op.eot) begin
            o_res_valid = 1'b1;
            o_res.kind  = KIND_EOT;
        end else if (hit) begin
            o_res_valid      = 1'b1;
            o_res.kind       = KIND_NOTE;
            o_res.key        = i_op.key;
            o_res.start_time = OUT_TIME_W'(start_q);
            o_res.duration   = OUT_TIME_W'(dur);
        end
    end

endmodule

[hw/rtl/mtne_out_buf.sv]
// Two-entry result buffer: output register plus skid register.
module mtne_out_buf
    import mtne_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_result    i_data,
    output logic       o_in_ready,
    mtne_res_if.source o_res
);

    logic    r_main_valid, r_skid_valid;
    t_result r_main, r_skid;
    logic    pop;

    assign pop        = r_main_valid && o_res.ready;
    assign o_in_ready = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_main_valid || pop) begin
                r_main_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_main_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_main <= r_skid;
            end
        end else if (i_push) begin
            if (!r_main_valid || pop) begin
                r_main <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end
    end

    assign o_res.valid      = r_main_valid;
    assign o_res.kind       = r_main.kind;
    assign o_res.key        = r_main.key;
    assign o_res.start_time = r_main.start_time;
    assign o_res.duration   = r_main.duration;

endmodule

[hw/rtl/mtne_checker.sv]
// Port-level checks of the note extractor and their bind.
`include "assert_macros.svh"

module mtne_checker #(
    parameter int NUM_KEYS = 128
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_out_kind,
    input logic [6:0]  i_out_key,
    input logic [31:0] i_out_start,
    input logic [31:0] i_out_dur
);

    // a stalled result holds its value
    `MTNE_ASSERT(a_res_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_key) && $stable(i_out_start) && $stable(i_out_dur) && $stable(i_out_kind)))

    // end of track results carry zero note fields
    `MTNE_ASSERT(a_eot_zero, i_clk, i_rst_n, (i_out_valid && i_out_kind) |-> (i_out_key == 7'd0 && i_out_start == 32'd0 && i_out_dur == 32'd0))

    // completed notes are within the key table
    `MTNE_ASSERT(a_key_range, i_clk, i_rst_n, (i_out_valid && !i_out_kind) |-> ({1'b0, i_out_key} < 8'(NUM_KEYS)))

    // reset empties the buffer and reopens the request side
    `MTNE_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> (!i_out_valid && i_in_ready))

endmodule

bind midi_track_note_extractor mtne_checker #(
    .NUM_KEYS (NUM_KEYS)
) u_mtne_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_kind  (o_res.kind),
    .i_out_key   (o_res.key),
    .i_out_start (o_res.start_time),
    .i_out_dur   (o_res.duration)
);
